### hw/rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants for the nearest palette colour search.
// ----------------------------------------------------------------------------
package npcs_pkg;

    // Field widths
    localparam int IDX_W  = 8;
    localparam int CH_W   = 8;
    localparam int SQ_W   = 2 * CH_W;
    localparam int DIST_W = 18;

    // Largest possible squared distance, 3 * 255 * 255
    localparam logic [DIST_W-1:0] DIST_MAX = 18'd195075;

    // Default palette depth
    localparam int PALETTE_SIZE_DEF = 256;

    // Request kinds
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_kind;

    // Item travelling down the chain of cells
    typedef struct packed {
        logic              valid;
        logic              is_query;
        logic [IDX_W-1:0]  slot;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
    } t_flow;

endpackage

### hw/rtl/npcs_if.sv
// ----------------------------------------------------------------------------
// npcs_if
// Request and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface npcs_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [npcs_pkg::IDX_W-1:0] entry_index;
    logic [npcs_pkg::CH_W-1:0]  red;
    logic [npcs_pkg::CH_W-1:0]  green;
    logic [npcs_pkg::CH_W-1:0]  blue;

    modport source (output valid, req_type, entry_index, red, green, blue, input ready);
    modport sink   (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [npcs_pkg::IDX_W-1:0] nearest_index;

    modport source (output valid, nearest_index, input ready);
    modport sink   (input valid, nearest_index, output ready);
endinterface

### hw/rtl/npcs_cell.sv
// ----------------------------------------------------------------------------
// npcs_cell
// One palette slot: holds its entry, squares the channel differences of a
// passing query, then folds its distance into the running best.
// ----------------------------------------------------------------------------
module npcs_cell #(
    parameter int CELL_ID = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  npcs_pkg::t_flow i_flow,
    output npcs_pkg::t_flow o_flow
);
    import npcs_pkg::*;

    localparam logic [IDX_W-1:0] ID_CODE = IDX_W'(CELL_ID);

    logic [CH_W-1:0] r_ent_r;
    logic [CH_W-1:0] r_ent_g;
    logic [CH_W-1:0] r_ent_b;

    t_flow           r_s1;
    t_flow           r_s2;
    logic [SQ_W-1:0] r_sq_r;
    logic [SQ_W-1:0] r_sq_g;
    logic [SQ_W-1:0] r_sq_b;

    logic [CH_W-1:0]   n_d_r;
    logic [CH_W-1:0]   n_d_g;
    logic [CH_W-1:0]   n_d_b;
    logic [DIST_W-1:0] n_dist;
    t_flow             n_s2;
    logic              w_load_hit;

    // Load aimed at this slot
    assign w_load_hit = i_flow.valid && !i_flow.is_query && (i_flow.slot == ID_CODE);

    // Entry register, written as the load passes by
    always_ff @(posedge i_clk) begin
        if (i_adv && w_load_hit) begin
            r_ent_r <= i_flow.red;
            r_ent_g <= i_flow.green;
            r_ent_b <= i_flow.blue;
        end
    end

    // Absolute channel differences
    always_comb begin
        n_d_r = (i_flow.red   >= r_ent_r) ? i_flow.red   - r_ent_r : r_ent_r - i_flow.red;
        n_d_g = (i_flow.green >= r_ent_g) ? i_flow.green - r_ent_g : r_ent_g - i_flow.green;
        n_d_b = (i_flow.blue  >= r_ent_b) ? i_flow.blue  - r_ent_b : r_ent_b - i_flow.blue;
    end

    // Stage 1: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1   <= i_flow;
            r_sq_r <= {{CH_W{1'b0}}, n_d_r} * {{CH_W{1'b0}}, n_d_r};
            r_sq_g <= {{CH_W{1'b0}}, n_d_g} * {{CH_W{1'b0}}, n_d_g};
            r_sq_b <= {{CH_W{1'b0}}, n_d_b} * {{CH_W{1'b0}}, n_d_b};
        end
    end

    // Sum and strict compare, so the lower index keeps a tie
    always_comb begin
        n_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
        n_s2   = r_s1;
        if (r_s1.is_query && (n_dist < r_s1.best_dist)) begin
            n_s2.best_dist = n_dist;
            n_s2.best_idx  = ID_CODE;
        end
    end

    // Stage 2: running best
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_adv) begin
            r_s2 <= n_s2;
        end
    end

    assign o_flow = r_s2;

`ifndef SYNTHESIS
    // After this cell a query always holds a real distance
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid && r_s2.is_query |-> r_s2.best_dist <= DIST_MAX)
        else $error("best distance out of range");

    // The best index never points past this cell
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2.valid && r_s2.is_query |-> r_s2.best_idx <= ID_CODE)
        else $error("best index beyond cell");

    // A matching load lands in the entry
    a_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && w_load_hit |=>
            r_ent_r == $past(i_flow.red) && r_ent_g == $past(i_flow.green) &&
            r_ent_b == $past(i_flow.blue))
        else $error("palette entry not written");

    // A stall freezes the cell
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_s2) && $stable(r_s1))
        else $error("cell moved during stall");
`endif

endmodule

### hw/rtl/nearest_palette_colour_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_colour_search
// Returns the index of the palette entry closest to a pixel by squared
// Euclidean distance; loads and queries run down one chain of slot cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake      payload
//  i_req    in         valid/ready    req_type, entry_index, red, green, blue
//  o_rsp    out        valid/ready    nearest_index
//
//  One request enters per cycle while the output is not stalled; a query result
//  passes the two register stages of each slot cell, then the output register.
//  Loads walk the same chain, so every query sees exactly the loads ahead of it.
//  A result held at the output without ready stalls the whole chain and i_req.
//  Synchronous reset clears the valid bits only; palette entries are unset.
// ----------------------------------------------------------------------------
module nearest_palette_colour_search #(
    parameter int PALETTE_SIZE = npcs_pkg::PALETTE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    npcs_req_if.sink   i_req,
    npcs_rsp_if.source o_rsp
);
    import npcs_pkg::*;

    t_flow             w_flow [0:PALETTE_SIZE];
    logic              w_adv;
    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_idx;

    // Chain moves whenever the output register can take a new value
    assign w_adv       = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_adv;

    // Head of the chain: a fresh query starts above any real distance
    always_comb begin
        w_flow[0].valid     = i_req.valid && w_adv;
        w_flow[0].is_query  = (i_req.req_type == REQ_QUERY);
        w_flow[0].slot      = i_req.entry_index;
        w_flow[0].red       = i_req.red;
        w_flow[0].green     = i_req.green;
        w_flow[0].blue      = i_req.blue;
        w_flow[0].best_dist = '1;
        w_flow[0].best_idx  = '0;
    end

    // One cell per palette slot
    for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
        npcs_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_flow  (w_flow[g]),
            .o_flow  (w_flow[g+1])
        );
    end

    // Output register; loads leave no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_flow[PALETTE_SIZE].valid && w_flow[PALETTE_SIZE].is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_idx <= w_flow[PALETTE_SIZE].best_idx;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.nearest_index = r_out_idx;

endmodule
